// ===== rtl/core/bb3ea_pkg.sv =====
// Shared types and constants of the 3x3 edge-aware box blur core.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package bb3ea_pkg;

    // Input word kinds carried on s_tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W     = 2;
    localparam logic [1:0]  CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0]  CFG_IMAGE_HEIGHT = 2'd1;
    localparam int          CFG_DATA_W      = 11;
    localparam int          WIDTH_RESET     = 640;
    localparam int          HEIGHT_RESET    = 480;

    // Sum of up to nine 8-bit samples, and the neighbor count (at most 9).
    localparam int SUM_W   = 12;
    localparam int COUNT_W = 4;

    // Reciprocals for exact floor division of values below 2**15.
    localparam int          RECIP_SHIFT = 16;
    localparam int          RECIP_W     = 15;
    localparam logic [14:0] RECIP_3     = 15'd21846;
    localparam logic [14:0] RECIP_9     = 15'd7282;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One window column: row above, center row, row below.
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    // One line buffer entry: the pixel two rows back and one row back.
    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_entry_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

    // Frame-edge masks and end marker that travel with a result.
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } win_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/box_blur_3x3_edge_aware_core.sv =====
// Top level of the 3x3 edge-aware box blur: frame counters, line buffer,
// a chain of three column cells, sum and divide stages and an output queue.
// Depends on bb3ea_pkg, bb3ea_line_buffer, bb3ea_column_cell, bb3ea_round_div.
//
//  Channel  Direction  Handshake                Payload
//  s_*      in         s_tvalid / s_tready      s_tdata (pixel), s_tuser (kind)
//  m_*      out        m_tvalid / m_tready      m_tdata (average), m_tlast
//  cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One word is taken per clock while s_tready is high; the line buffer's
// single write and read port and the three-cell window shift set that
// rate. A result passes stages 1, 2 and 3 and then the output queue on its
// way to m_tvalid. Reset clears the counters and queue at once; the line
// buffer needs no clearing pass. When m_tready is low, the two-entry output
// queue and three stages fill before s_tready drops.
`default_nettype none

module box_blur_3x3_edge_aware_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    // Input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  wire         s_tuser,   // operation [0]
    // Output stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic        m_tlast,   // frame_last
    // Configuration writes.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [bb3ea_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [bb3ea_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int LW = $clog2(MAX_WIDTH + 2);
    localparam int W_RESET = (bb3ea_pkg::WIDTH_RESET > MAX_WIDTH) ?
                             MAX_WIDTH : bb3ea_pkg::WIDTH_RESET;
    localparam int H_RESET = (bb3ea_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                             MAX_HEIGHT : bb3ea_pkg::HEIGHT_RESET;

    // Register values of zero act as one; larger than the maximum act as it.
    function automatic logic [DW-1:0] clamp_w(input logic [bb3ea_pkg::CFG_DATA_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
            r = DW'(1);
        else if (32'(v) > MAX_WIDTH)
            r = DW'(MAX_WIDTH);
        else
            r = DW'(v);
        return r;
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [bb3ea_pkg::CFG_DATA_W-1:0] v);
        logic [HW-1:0] r;
        if (v == '0)
            r = HW'(1);
        else if (32'(v) > MAX_HEIGHT)
            r = HW'(MAX_HEIGHT);
        else
            r = HW'(v);
        return r;
    endfunction

    // Frame size registers.
    logic [DW-1:0] ew_reg;
    logic [HW-1:0] eh_reg;
    logic          cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       ((cfg_index == bb3ea_pkg::CFG_IMAGE_WIDTH) ||
                        (cfg_index == bb3ea_pkg::CFG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg <= DW'(W_RESET);
            eh_reg <= HW'(H_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == bb3ea_pkg::CFG_IMAGE_WIDTH)
            begin
                ew_reg <= clamp_w(cfg_data);
            end
            else if (cfg_index == bb3ea_pkg::CFG_IMAGE_HEIGHT)
            begin
                eh_reg <= clamp_h(cfg_data);
            end
        end
    end

    // Stage enables, from the output queue back to the input.
    logic        s1_v_reg, s2_v_reg, s3_v_reg;
    logic [1:0]  q_count_reg;
    logic        en1, en2, en3;
    logic        q_push, q_pop;

    assign q_push   = s3_v_reg && (q_count_reg != 2'd2);
    assign en3      = !s3_v_reg || (q_count_reg != 2'd2);
    assign en2      = !s2_v_reg || en3;
    assign en1      = !s1_v_reg || en2;
    assign s_tready = en1;

    // Frame position counters.
    logic [AW-1:0] ic_reg, ic_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic          in_done_reg, in_done_next;
    logic [LW-1:0] lead_reg, lead_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic          accept, effective, result, frame_end;
    logic          lead_full, ic_last, in_last_row, out_col_last, out_row_last;
    logic [LW-1:0] lead_target;

    assign accept       = s_tvalid && s_tready;
    assign effective    = accept && (in_done_reg || (s_tuser == bb3ea_pkg::OP_PIXEL));
    assign lead_target  = LW'(ew_reg) + LW'(1);
    assign lead_full    = (lead_reg == lead_target);
    assign result       = effective && lead_full;
    assign ic_last      = (DW'(ic_reg) == (ew_reg - DW'(1)));
    assign in_last_row  = (HW'(in_row_reg) == (eh_reg - HW'(1)));
    assign out_col_last = (DW'(out_col_reg) == (ew_reg - DW'(1)));
    assign out_row_last = (HW'(out_row_reg) == (eh_reg - HW'(1)));
    assign frame_end    = result && out_col_last && out_row_last;

    always_comb
    begin
        ic_next      = ic_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        lead_next    = lead_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_hit || (effective && frame_end))
        begin
            ic_next      = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            lead_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (effective)
        begin
            ic_next = ic_last ? '0 : ic_reg + AW'(1);
            if (!in_done_reg && ic_last)
            begin
                if (in_last_row)
                    in_done_next = 1'b1;
                else
                    in_row_next = in_row_reg + RW'(1);
            end
            if (!lead_full)
            begin
                lead_next = lead_reg + LW'(1);
            end
            if (result)
            begin
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg      <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            lead_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            ic_reg      <= ic_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            lead_reg    <= lead_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Line buffer: the read port always looks at the next word's column.
    bb3ea_pkg::pixel_t      in_pixel;
    bb3ea_pkg::line_entry_t lb_rd, lb_wr;
    bb3ea_pkg::column_t     new_col;

    assign in_pixel.red   = s_tdata[7:0];
    assign in_pixel.green = s_tdata[15:8];
    assign in_pixel.blue  = s_tdata[23:16];
    assign lb_wr.upper    = lb_rd.lower;
    assign lb_wr.lower    = in_pixel;
    assign new_col.top    = lb_rd.upper;
    assign new_col.mid    = lb_rd.lower;
    assign new_col.bot    = in_pixel;

    bb3ea_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk     (clk),
        .wr_en   (effective),
        .wr_addr (ic_reg),
        .wr_data (lb_wr),
        .rd_addr (ic_next),
        .rd_data (lb_rd)
    );

    // Stage 1: edge masks of the result whose window was just completed.
    bb3ea_pkg::win_ctrl_t s1_ctrl_reg, s2_ctrl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_v_reg <= result;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ctrl_reg.top_ok   <= (out_row_reg != '0);
            s1_ctrl_reg.bot_ok   <= !out_row_last;
            s1_ctrl_reg.left_ok  <= (out_col_reg != '0);
            s1_ctrl_reg.right_ok <= !out_col_last;
            s1_ctrl_reg.last     <= out_col_last && out_row_last;
        end
        if (en2)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    // Window chain: cell 0 is the right column, cell 2 the left.
    bb3ea_pkg::column_t col0, col1, col2;
    bb3ea_pkg::sum_t    sum0, sum1, sum2;

    bb3ea_column_cell u_cell_right (
        .clk      (clk),
        .shift_en (effective),
        .col_in   (new_col),
        .col_out  (col0),
        .sum_en   (en2),
        .top_ok   (s1_ctrl_reg.top_ok),
        .bot_ok   (s1_ctrl_reg.bot_ok),
        .col_sum  (sum0)
    );

    bb3ea_column_cell u_cell_center (
        .clk      (clk),
        .shift_en (effective),
        .col_in   (col0),
        .col_out  (col1),
        .sum_en   (en2),
        .top_ok   (s1_ctrl_reg.top_ok),
        .bot_ok   (s1_ctrl_reg.bot_ok),
        .col_sum  (sum1)
    );

    bb3ea_column_cell u_cell_left (
        .clk      (clk),
        .shift_en (effective),
        .col_in   (col1),
        .col_out  (col2),
        .sum_en   (en2),
        .top_ok   (s1_ctrl_reg.top_ok),
        .bot_ok   (s1_ctrl_reg.bot_ok),
        .col_sum  (sum2)
    );

    // Stage 3: window sum over the columns inside the frame, and its count.
    bb3ea_pkg::sum_t               s3_sum_reg, win_sum;
    logic [bb3ea_pkg::COUNT_W-1:0] s3_count_reg, win_count;
    logic                          s3_last_reg;
    logic [1:0]                    rows_in, cols_in;

    always_comb
    begin
        win_sum.red   = sum1.red
                      + (s2_ctrl_reg.left_ok  ? sum2.red : '0)
                      + (s2_ctrl_reg.right_ok ? sum0.red : '0);
        win_sum.green = sum1.green
                      + (s2_ctrl_reg.left_ok  ? sum2.green : '0)
                      + (s2_ctrl_reg.right_ok ? sum0.green : '0);
        win_sum.blue  = sum1.blue
                      + (s2_ctrl_reg.left_ok  ? sum2.blue : '0)
                      + (s2_ctrl_reg.right_ok ? sum0.blue : '0);
        rows_in   = 2'd1 + 2'(s2_ctrl_reg.top_ok) + 2'(s2_ctrl_reg.bot_ok);
        cols_in   = 2'd1 + 2'(s2_ctrl_reg.left_ok) + 2'(s2_ctrl_reg.right_ok);
        win_count = bb3ea_pkg::COUNT_W'(rows_in) * bb3ea_pkg::COUNT_W'(cols_in);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_sum_reg   <= win_sum;
            s3_count_reg <= win_count;
            s3_last_reg  <= s2_ctrl_reg.last;
        end
    end

    // Divide stage feeds the output queue directly.
    bb3ea_pkg::pixel_t avg;

    bb3ea_round_div u_round_div (
        .sum   (s3_sum_reg),
        .count (s3_count_reg),
        .avg   (avg)
    );

    // Two-entry output queue; its full flag alone stalls the stages.
    bb3ea_pkg::pixel_t q_pix_reg  [2];
    logic              q_last_reg [2];
    logic              q_wr_reg, q_rd_reg;

    assign q_pop = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= 2'd0;
            q_wr_reg    <= 1'b0;
            q_rd_reg    <= 1'b0;
        end
        else
        begin
            q_count_reg <= q_count_reg + 2'(q_push) - 2'(q_pop);
            if (q_push)
            begin
                q_wr_reg <= !q_wr_reg;
            end
            if (q_pop)
            begin
                q_rd_reg <= !q_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_pix_reg[q_wr_reg]  <= avg;
            q_last_reg[q_wr_reg] <= s3_last_reg;
        end
    end

    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tdata  = {q_pix_reg[q_rd_reg].blue, q_pix_reg[q_rd_reg].green,
                       q_pix_reg[q_rd_reg].red};
    assign m_tlast  = q_last_reg[q_rd_reg];

    // The result position never leaves the frame.
    a_out_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (DW'(out_col_reg) < ew_reg) && (HW'(out_row_reg) < eh_reg))
        else $error("result position outside the frame");

    // The frame's final result restarts all frame counters.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> ((lead_reg == '0) && !in_done_reg && (ic_reg == '0) &&
                       (out_col_reg == '0) && (out_row_reg == '0)))
        else $error("frame counters not restarted after the final result");

    // Input completes only on the last row.
    a_done_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_done_reg |-> (HW'(in_row_reg) == (eh_reg - HW'(1))))
        else $error("input marked complete before the last row");

endmodule

`default_nettype wire

// ===== rtl/core/bb3ea_line_buffer.sv =====
// Two-row line buffer of the box blur core: one write and one read port,
// registered read with write-through. Depends on bb3ea_pkg.
`default_nettype none

module bb3ea_line_buffer #(
    parameter int DEPTH = 1024
) (
    input  wire                                 clk,
    input  wire                                 wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  bb3ea_pkg::line_entry_t              wr_data,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output bb3ea_pkg::line_entry_t              rd_data
);

    bb3ea_pkg::line_entry_t mem_reg [DEPTH];
    bb3ea_pkg::line_entry_t rd_data_reg;

    // A read of the address written in the same cycle returns the new data,
    // which a row of one pixel needs.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bb3ea_column_cell.sv =====
// One cell of the window chain: holds a three-pixel column, passes it to
// the next cell, and registers its masked column sum. Depends on bb3ea_pkg.
`default_nettype none

module bb3ea_column_cell (
    input  wire                  clk,
    input  wire                  shift_en,
    input  bb3ea_pkg::column_t   col_in,
    output bb3ea_pkg::column_t   col_out,
    input  wire                  sum_en,
    input  wire                  top_ok,
    input  wire                  bot_ok,
    output bb3ea_pkg::sum_t      col_sum
);

    bb3ea_pkg::column_t col_reg;
    bb3ea_pkg::sum_t    sum_reg;
    bb3ea_pkg::sum_t    sum_next;

    // Column storage moves one cell down the chain per word.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    // Rows outside the frame are left out of the sum.
    always_comb
    begin
        sum_next.red   = bb3ea_pkg::SUM_W'(col_reg.mid.red)
                       + bb3ea_pkg::SUM_W'(top_ok ? col_reg.top.red : 8'd0)
                       + bb3ea_pkg::SUM_W'(bot_ok ? col_reg.bot.red : 8'd0);
        sum_next.green = bb3ea_pkg::SUM_W'(col_reg.mid.green)
                       + bb3ea_pkg::SUM_W'(top_ok ? col_reg.top.green : 8'd0)
                       + bb3ea_pkg::SUM_W'(bot_ok ? col_reg.bot.green : 8'd0);
        sum_next.blue  = bb3ea_pkg::SUM_W'(col_reg.mid.blue)
                       + bb3ea_pkg::SUM_W'(top_ok ? col_reg.top.blue : 8'd0)
                       + bb3ea_pkg::SUM_W'(bot_ok ? col_reg.bot.blue : 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bb3ea_round_div.sv =====
// Rounded average of a window sum over its neighbor count (1, 2, 3, 4, 6
// or 9), halves up, by shifts and reciprocal multiplies. Depends on bb3ea_pkg.
`default_nettype none

module bb3ea_round_div (
    input  bb3ea_pkg::sum_t                       sum,
    input  wire [bb3ea_pkg::COUNT_W-1:0]          count,
    output bb3ea_pkg::pixel_t                     avg
);

    localparam int XW = bb3ea_pkg::SUM_W + 1;
    localparam int PW = bb3ea_pkg::SUM_W + bb3ea_pkg::RECIP_W;

    // floor((2*s + n) / (2*n)); odd factors 3 and 9 use a reciprocal.
    function automatic logic [7:0] chan_div(
        input logic [bb3ea_pkg::SUM_W-1:0]   s,
        input logic [bb3ea_pkg::COUNT_W-1:0] n
    );
        logic [XW-1:0]                        x;
        logic [bb3ea_pkg::SUM_W-1:0]          y;
        logic [bb3ea_pkg::RECIP_W-1:0]        m;
        logic [PW-1:0]                        prod;
        logic [XW-1:0]                        q;
        logic                                 use_mul;
        x       = {s, 1'b0} + XW'(n);
        y       = x[XW-1:1];
        m       = bb3ea_pkg::RECIP_3;
        use_mul = 1'b0;
        q       = '0;
        case (n)
            4'd1: q = x >> 1;
            4'd2: q = x >> 2;
            4'd3:
            begin
                y       = x[XW-1:1];
                use_mul = 1'b1;
            end
            4'd4: q = x >> 3;
            4'd6:
            begin
                y       = bb3ea_pkg::SUM_W'(x >> 2);
                use_mul = 1'b1;
            end
            4'd9:
            begin
                y       = x[XW-1:1];
                m       = bb3ea_pkg::RECIP_9;
                use_mul = 1'b1;
            end
            default: q = '0;
        endcase
        prod = PW'(y) * PW'(m);
        if (use_mul)
        begin
            q = XW'(prod >> bb3ea_pkg::RECIP_SHIFT);
        end
        return q[7:0];
    endfunction

    assign avg.red   = chan_div(sum.red, count);
    assign avg.green = chan_div(sum.green, count);
    assign avg.blue  = chan_div(sum.blue, count);

endmodule

`default_nettype wire

// ===== sim/box_blur_3x3_edge_aware_core_tb.sv =====
// Self-checking bench for the 3x3 edge-aware box blur core: a directed table,
// then random frames of many sizes under four idle/stall mixes.
// Depends on bb3ea_pkg and box_blur_3x3_edge_aware_core.
`default_nettype none

module box_blur_3x3_edge_aware_core_tb;

    import bb3ea_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int HIST_DEPTH   = 2 * MAX_W + 2;
    localparam int SETTLE       = 8;
    localparam int MAX_GAP      = 60;
    localparam int MAX_STALL    = 40;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_WORDS  = 420;
    localparam int PRINT_LIMIT  = 50;

    // Register index that the core does not decode.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd2;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // One row of the directed table; pixels are written as 24'hRRGGBB.
    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]    value;
        logic                     op;
        pixel_t                   pix;
        logic                     typed;
        pixel_t                   want;
        logic                     want_last;
    } stim_row_t;

    typedef struct packed {
        pixel_t avg;
        logic   last;
    } blurred_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;
    logic                   s_tuser   = OP_PIXEL;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Typed expectation that travels with the word on the bus.
    logic     row_typed = 1'b0;
    blurred_t row_want  = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int stall_run     = 0;
    int quiet_cycles  = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;

    // Predictor state.
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pixel_t                history [HIST_DEPTH];
    int                    hist_slot;
    int                    out_col;
    int                    out_row;
    int                    words_in_frame;
    blurred_t              blurred_q [$];

    box_blur_3x3_edge_aware_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // red_in [7:0], green_in [15:8], blue_in [23:16]
        .s_tuser   (s_tuser),   // operation [0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // red_out [7:0], green_out [15:8], blue_out [23:16]
        .m_tlast   (m_tlast),   // frame_last
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // A size register of zero acts as one; anything above the maximum is clipped.
    function automatic int effective_size(input logic [CFG_DATA_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    // Round to nearest with halves going up.
    function automatic logic [7:0] round_mean(input int sum, input int cnt);
        return 8'((2 * sum + cnt) / (2 * cnt));
    endfunction

    // Advance the blur state by one accepted word; returns 1 when a result is due.
    function automatic logic blur_predict(input logic op, input pixel_t pix,
                                          output pixel_t avg, output logic last);
        int     ew;
        int     eh;
        int     pos;
        int     cur;
        int     r;
        int     c;
        int     back;
        int     slot;
        int     cnt;
        int     sum_r;
        int     sum_g;
        int     sum_b;
        pixel_t px;
        ew    = effective_size(width_reg, MAX_W);
        eh    = effective_size(height_reg, MAX_H);
        pos   = words_in_frame;
        cur   = hist_slot;
        avg   = '0;
        last  = 1'b0;
        cnt   = 0;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;

        // Before the last pixel, drains are dropped; afterwards pixels count as drains.
        if (pos < ew * eh)
        begin
            if (op == OP_DRAIN)
                return 1'b0;
            history[cur] = pix;
        end
        hist_slot      = (cur + 1) % HIST_DEPTH;
        words_in_frame = pos + 1;
        if (pos < ew + 1)
            return 1'b0;

        // Sum the neighbors that fall inside the frame.
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                r = out_row + dr;
                c = out_col + dc;
                if (r >= 0 && c >= 0 && r < eh && c < ew)
                begin
                    back  = ew + 1 - dr * ew - dc;
                    slot  = (cur + HIST_DEPTH - back) % HIST_DEPTH;
                    px    = history[slot];
                    sum_r += px.red;
                    sum_g += px.green;
                    sum_b += px.blue;
                    cnt++;
                end
            end
        end
        avg.red   = round_mean(sum_r, cnt);
        avg.green = round_mean(sum_g, cnt);
        avg.blue  = round_mean(sum_b, cnt);
        last      = (out_row == eh - 1) && (out_col == ew - 1);

        if (last)
        begin
            out_col        = 0;
            out_row        = 0;
            words_in_frame = 0;
        end
        else
        begin
            out_col++;
            if (out_col >= ew)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch in %s at result %0d: got %0d, want %0d",
                     field, results_seen, got, want);
    endtask

    // Prediction on every accepted word and register write, checking on every result.
    always @(posedge clk)
    begin : monitor
        pixel_t   in_pix;
        pixel_t   avg;
        logic     last;
        blurred_t exp_word;
        if (!rst_n)
        begin
            width_reg      = CFG_DATA_W'(WIDTH_RESET);
            height_reg     = CFG_DATA_W'(HEIGHT_RESET);
            hist_slot      = 0;
            out_col        = 0;
            out_row        = 0;
            words_in_frame = 0;
        end
        else
        begin
            // A write to either size register abandons the frame.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)
                begin
                    if (cfg_index == CFG_IMAGE_WIDTH)
                        width_reg = cfg_data;
                    else
                        height_reg = cfg_data;
                    out_col        = 0;
                    out_row        = 0;
                    words_in_frame = 0;
                end
            end

            if (s_tvalid && s_tready)
            begin
                in_pix.red   = s_tdata[7:0];
                in_pix.green = s_tdata[15:8];
                in_pix.blue  = s_tdata[23:16];
                if (blur_predict(s_tuser, in_pix, avg, last))
                begin
                    if (row_typed)
                        blurred_q.push_back(row_want);
                    else
                        blurred_q.push_back('{avg: avg, last: last});
                end
            end

            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (blurred_q.size() == 0)
                    report_mismatch("result with nothing pending", int'(m_tdata), 0);
                else
                begin
                    exp_word = blurred_q.pop_front();
                    if (m_tdata[7:0] != exp_word.avg.red)
                        report_mismatch("red_out", m_tdata[7:0], exp_word.avg.red);
                    if (m_tdata[15:8] != exp_word.avg.green)
                        report_mismatch("green_out", m_tdata[15:8], exp_word.avg.green);
                    if (m_tdata[23:16] != exp_word.avg.blue)
                        report_mismatch("blue_out", m_tdata[23:16], exp_word.avg.blue);
                    if (m_tlast != exp_word.last)
                        report_mismatch("frame_last", m_tlast, exp_word.last);
                end
            end
        end
    end

    // Receiver: random stalls, with no run of them longer than MAX_STALL.
    always @(posedge clk)
    begin
        if (stall_run >= MAX_STALL || $urandom_range(99) >= stall_pct)
        begin
            m_tready  <= 1'b1;
            stall_run <= 0;
        end
        else
        begin
            m_tready  <= 1'b0;
            stall_run <= stall_run + 1;
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Send one word; valid stays high afterwards only when the next word follows at once.
    task automatic drive_word(input logic op, input pixel_t pix, input logic typed,
                              input pixel_t want, input logic want_last);
        int gap;
        s_tvalid  <= 1'b1;
        s_tdata   <= {pix.blue, pix.green, pix.red};
        s_tuser   <= op;
        row_typed <= typed;
        row_want  <= '{avg: want, last: want_last};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending, wait for every pending result, then let the pipeline settle.
    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_idle(SETTLE);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One frame in raster order followed by its flush; noise adds early drains
    // and swaps flush drains for extra pixels. stop_at cuts the frame short.
    task automatic blur_frame(input int cols, input int rows, input int noise_pct,
                              input int stop_at, input int hold_at);
        int          total;
        logic [31:0] bits;
        pixel_t      pix;
        total = cols * rows;
        for (int k = 0; k < total; k++)
        begin
            if (k == stop_at)
                return;
            if (k == hold_at)
                wait_idle(1);
            if ($urandom_range(99) < noise_pct)
            begin
                bits = $urandom;
                drive_word(OP_DRAIN, bits[23:0], 1'b0, '0, 1'b0);
            end
            bits = $urandom;
            case ($urandom_range(9))
                0:       pix = '0;
                1:       pix = '1;
                default: pix = bits[23:0];
            endcase
            drive_word(OP_PIXEL, pix, 1'b0, '0, 1'b0);
        end
        for (int k = 0; k <= cols; k++)
        begin
            bits = $urandom;
            if ($urandom_range(99) < noise_pct)
                drive_word(OP_PIXEL, bits[23:0], 1'b0, '0, 1'b0);
            else
                drive_word(OP_DRAIN, bits[23:0], 1'b0, '0, 1'b0);
        end
    endtask

    // Directed rows: a 1x1 frame from zero sizes with an early drain and an
    // extra pixel, a 2x2 frame whose averages round a half upward, and a 3x3
    // frame with a write to an undecoded register index in the middle.
    stim_row_t directed_rows [32] = '{
        '{ROW_CFG,  CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_CFG,  CFG_IMAGE_HEIGHT, 11'd0, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'h123456, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFF0080, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h00FF7F, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'hA5A5A5, 1'b1, 24'hFF0080, 1'b1},
        '{ROW_CFG,  CFG_IMAGE_WIDTH,  11'd2, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_CFG,  CFG_IMAGE_HEIGHT, 11'd2, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFF0001, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFF0001, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'h5A5A5A, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFF0000, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFF0000, 1'b1, 24'hFF0001, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'h000000, 1'b1, 24'hFF0001, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'hFFFFFF, 1'b1, 24'hFF0001, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'h000000, 1'b1, 24'hFF0001, 1'b1},
        '{ROW_CFG,  CFG_IMAGE_WIDTH,  11'd3, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_CFG,  CFG_IMAGE_HEIGHT, 11'd3, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h010203, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h80FF00, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
        '{ROW_CFG,  CFG_UNUSED,     11'h7FF, OP_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h7F7F7F, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h00FF00, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'h123456, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_PIXEL, 24'hFEDCBA, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'hC3C3C3, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'h3C3C3C, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
        '{ROW_WORD, CFG_IMAGE_WIDTH,  11'd0, OP_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0}
    };

    // Largest frames: width at and beyond its maximum, height at and beyond its maximum.
    int big_w [4] = '{1024, 2047, 1, 1};
    int big_h [4] = '{1, 1, 1024, 2047};

    // Idle and stall mix of each random phase.
    int idle_of  [4] = '{0, 82, 0, 33};
    int stall_of [4] = '{0, 0, 82, 33};

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] raw_w;
        logic [CFG_DATA_W-1:0] raw_h;
        int                    cols;
        int                    rows;
        int                    stop_at;
        int                    phase_end;
        logic                  need_cfg;
        logic                  hold;
        raw_w = '0;
        raw_h = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Part of a frame at the reset size; the first register write abandons it.
        blur_frame(WIDTH_RESET, HEIGHT_RESET, 0, WIDTH_RESET + 8, -1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_register(directed_rows[i].index, directed_rows[i].value);
            else
                drive_word(directed_rows[i].op, directed_rows[i].pix, directed_rows[i].typed,
                           directed_rows[i].want, directed_rows[i].want_last);
        end

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_of[p];
            stall_pct     = stall_of[p];

            if (p == 0)
            begin
                foreach (big_w[i])
                begin
                    write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(big_w[i]));
                    write_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(big_h[i]));
                    blur_frame(effective_size(CFG_DATA_W'(big_w[i]), MAX_W),
                               effective_size(CFG_DATA_W'(big_h[i]), MAX_H), 2, -1, -1);
                end
            end

            // Mostly small frames; some keep their size and run back to back.
            phase_end = words_sent + PHASE_WORDS;
            need_cfg  = 1'b1;
            hold      = 1'b1;
            while (words_sent < phase_end)
            begin
                if (need_cfg || $urandom_range(9) < 6)
                begin
                    case ($urandom_range(19))
                        0:       raw_w = '0;
                        1:       raw_w = CFG_DATA_W'($urandom_range(9, 40));
                        default: raw_w = CFG_DATA_W'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(19))
                        0:       raw_h = '0;
                        1:       raw_h = CFG_DATA_W'($urandom_range(7, 20));
                        default: raw_h = CFG_DATA_W'($urandom_range(1, 6));
                    endcase
                    if ($urandom_range(1) == 0)
                    begin
                        write_register(CFG_IMAGE_WIDTH, raw_w);
                        write_register(CFG_IMAGE_HEIGHT, raw_h);
                    end
                    else
                    begin
                        write_register(CFG_IMAGE_HEIGHT, raw_h);
                        write_register(CFG_IMAGE_WIDTH, raw_w);
                    end
                end
                cols    = effective_size(raw_w, MAX_W);
                rows    = effective_size(raw_h, MAX_H);
                stop_at = ($urandom_range(9) == 0) ? $urandom_range(cols * rows - 1) : -1;
                blur_frame(cols, rows, 5, stop_at, hold ? (cols * rows) / 2 : -1);
                hold     = 1'b0;
                need_cfg = (stop_at >= 0);
            end
        end

        wait_idle(20);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/bb3ea_pkg.sv
rtl/core/bb3ea_line_buffer.sv
rtl/core/bb3ea_column_cell.sv
rtl/core/bb3ea_round_div.sv
rtl/core/box_blur_3x3_edge_aware_core.sv
sim/box_blur_3x3_edge_aware_core_tb.sv
